FILE: rtl/assert_macros.svh
// assertion macros used by the checker file php_checker.sv
// no dependencies; guarded against double inclusion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in the same cycle implies consequent
`define PHP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/php_pkg.sv
// shared types and constants of the p6 header parser
// no dependencies
package php_pkg;

  localparam int unsigned DIM_BITS = 16;

  // largest decimal value a dimension may take
  localparam logic [19:0] ACC_LIMIT = 20'((1 << DIM_BITS) - 1);

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [15:0] MAXVAL  = 16'd255;

  typedef enum logic [6:0] {
    PH_P      = 7'b0000001,
    PH_SIX    = 7'b0000010,
    PH_NL     = 7'b0000100,
    PH_WIDTH  = 7'b0001000,
    PH_HEIGHT = 7'b0010000,
    PH_MAXV   = 7'b0100000,
    PH_PIXELS = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_TAKEN = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_PIXEL = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pixel_value;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic        last_pixel;
  } result_t;

endpackage

FILE: rtl/php_frame_size.sv
// registered frame size: width * height * 3 pixel bytes
// depends on no other file
module php_frame_size (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] width_i,
  input  logic [15:0] height_i,
  output logic [33:0] total_o,
  output logic        zero_o
);

  logic [31:0] prod_q;
  logic [31:0] prod_d;

  assign prod_d = width_i * height_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else begin
      prod_q <= prod_d;
    end
  end

  // times three as shift plus add
  assign total_o = {2'b00, prod_q} + {1'b0, prod_q, 1'b0};
  assign zero_o  = (prod_q == 32'd0);

endmodule

FILE: rtl/php_parser.sv
// header matching state machine, number gathering and pixel countdown
// depends on php_pkg and php_frame_size
module php_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output php_pkg::result_t result_o
);

  php_pkg::phase_e phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic        seen_q, seen_d;
  logic [15:0] held_w_q, held_w_d;
  logic [15:0] held_h_q, held_h_d;
  logic [33:0] left_q, left_d;

  logic [33:0] total;
  logic        total_zero;

  logic        is_digit;
  logic [19:0] acc_next;
  logic        overflow;
  logic        err;

  php_frame_size u_size (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .width_i (held_w_q),
    .height_i(held_h_q),
    .total_o (total),
    .zero_o  (total_zero)
  );

  assign is_digit = (byte_i >= php_pkg::CH_ZERO) && (byte_i <= php_pkg::CH_NINE);
  // acc * 10 + digit
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {16'd0, byte_i[3:0]};
  assign overflow = acc_next > php_pkg::ACC_LIMIT;

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    seen_d   = seen_q;
    held_w_d = held_w_q;
    held_h_d = held_h_q;
    left_d   = left_q;
    err      = 1'b0;
    result_o = '{kind: php_pkg::KIND_TAKEN, pixel_value: 8'd0, frame_width: 16'd0,
                 frame_height: 16'd0, last_pixel: 1'b0};

    case (phase_q)
      php_pkg::PH_SIX: begin
        if (byte_i == php_pkg::CH_SIX) phase_d = php_pkg::PH_NL;
        else err = 1'b1;
      end
      php_pkg::PH_NL: begin
        if (byte_i == php_pkg::CH_NL) begin
          phase_d = php_pkg::PH_WIDTH;
          acc_d   = '0;
          seen_d  = 1'b0;
        end else begin
          err = 1'b1;
        end
      end
      php_pkg::PH_WIDTH, php_pkg::PH_HEIGHT, php_pkg::PH_MAXV: begin
        if (is_digit) begin
          if (overflow) begin
            err = 1'b1;
          end else begin
            acc_d  = acc_next[15:0];
            seen_d = 1'b1;
          end
        end else if (seen_q && phase_q == php_pkg::PH_WIDTH && byte_i == php_pkg::CH_SPACE) begin
          held_w_d = acc_q;
          acc_d    = '0;
          seen_d   = 1'b0;
          phase_d  = php_pkg::PH_HEIGHT;
        end else if (seen_q && phase_q == php_pkg::PH_HEIGHT && byte_i == php_pkg::CH_NL) begin
          held_h_d = acc_q;
          acc_d    = '0;
          seen_d   = 1'b0;
          phase_d  = php_pkg::PH_MAXV;
        end else if (seen_q && phase_q == php_pkg::PH_MAXV && byte_i == php_pkg::CH_NL
                     && acc_q == php_pkg::MAXVAL) begin
          // frame size product has settled: the maximum took at least three digits
          result_o.kind         = php_pkg::KIND_DONE;
          result_o.frame_width  = held_w_q;
          result_o.frame_height = held_h_q;
          acc_d   = '0;
          seen_d  = 1'b0;
          left_d  = total;
          phase_d = total_zero ? php_pkg::PH_P : php_pkg::PH_PIXELS;
        end else begin
          err = 1'b1;
        end
      end
      php_pkg::PH_PIXELS: begin
        result_o.kind         = php_pkg::KIND_PIXEL;
        result_o.pixel_value  = byte_i;
        result_o.frame_width  = held_w_q;
        result_o.frame_height = held_h_q;
        if (left_q[33:1] == '0) begin
          result_o.last_pixel = 1'b1;
          left_d  = '0;
          phase_d = php_pkg::PH_P;
        end else begin
          left_d = left_q - 34'd1;
        end
      end
      default: begin
        if (byte_i == php_pkg::CH_P) phase_d = php_pkg::PH_SIX;
        else err = 1'b1;
      end
    endcase

    if (err) begin
      result_o.kind = php_pkg::KIND_ERROR;
      phase_d = php_pkg::PH_P;
      acc_d   = '0;
      seen_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= php_pkg::PH_P;
      acc_q    <= '0;
      seen_q   <= 1'b0;
      held_w_q <= '0;
      held_h_q <= '0;
      left_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      seen_q   <= seen_d;
      held_w_q <= held_w_d;
      held_h_q <= held_h_d;
      left_q   <= left_d;
    end
  end

endmodule

FILE: rtl/ppm_p6_header_parser_core.sv
// two register stages: the input byte register, then the result register
// throughput: one byte per cycle unless stalled, set by the single-pass header/pixel state update
// frame size multiply is registered and settles while the maximum value digits arrive
// reset: asynchronous, active low; parser expects letter P, counters and sizes cleared,
// both pipeline stages empty
module ppm_p6_header_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  pixel_value_o,
  output logic [15:0] frame_width_o,
  output logic [15:0] frame_height_o,
  output logic        last_pixel_o
);

  // input register stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;

  // result register stage
  logic             out_valid_q;
  php_pkg::result_t out_q;
  php_pkg::result_t res;

  logic advance;
  logic step;

  // result register frees when empty or being taken
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  // a held byte moves into the result register: parser state commits
  assign step       = s1_valid_q && advance;

  php_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (s1_byte_q),
    .result_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (advance) out_valid_q <= s1_valid_q;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) s1_byte_q <= stream_byte_i;
    if (step) out_q <= res;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign pixel_value_o  = out_q.pixel_value;
  assign frame_width_o  = out_q.frame_width;
  assign frame_height_o = out_q.frame_height;
  assign last_pixel_o   = out_q.last_pixel;

endmodule

FILE: rtl/php_checker.sv
// port-level checks of the p6 header parser output transactions
// depends on assert_macros.svh and php_pkg; bound to ppm_p6_header_parser_core
`include "assert_macros.svh"

module php_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  pixel_value_o,
  input logic [15:0] frame_width_o,
  input logic [15:0] frame_height_o,
  input logic        last_pixel_o
);

  logic        stalled;
  logic        is_pixel;
  logic        no_dims;
  logic        dims_zero;
  logic [42:0] payload;

  assign stalled   = out_valid_o && !out_ready_i;
  assign is_pixel  = (kind_o == php_pkg::KIND_PIXEL);
  assign no_dims   = (kind_o == php_pkg::KIND_TAKEN) || (kind_o == php_pkg::KIND_ERROR);
  assign dims_zero = (frame_width_o == 16'd0) && (frame_height_o == 16'd0);
  assign payload   = {kind_o, pixel_value_o, frame_width_o, frame_height_o, last_pixel_o};

  `PHP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_o && $stable(payload))
  `PHP_ASSERT_IMPLY(a_last_only_pixel, clk_i, rst_ni, out_valid_o && last_pixel_o, is_pixel)
  `PHP_ASSERT_IMPLY(a_pixel_zero, clk_i, rst_ni, out_valid_o && !is_pixel, pixel_value_o == 8'd0)
  `PHP_ASSERT_IMPLY(a_dims_zero, clk_i, rst_ni, out_valid_o && no_dims, dims_zero)

endmodule

bind ppm_p6_header_parser_core php_checker u_php_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .kind_o        (kind_o),
  .pixel_value_o (pixel_value_o),
  .frame_width_o (frame_width_o),
  .frame_height_o(frame_height_o),
  .last_pixel_o  (last_pixel_o)
);

FILE: sim/ppm_p6_header_parser_core_tb.sv
// testbench for ppm_p6_header_parser_core: p6 header parsing and pixel pass-through
// predicts every result in a scoreboard class; needs php_pkg and the core rtl
`timescale 1ns / 1ps

module ppm_p6_header_parser_core_tb;

  import php_pkg::*;

  // results are compared in order, so a plain fifo of predictions is enough
  class frame_scoreboard;
    phase_e      phase;
    logic [19:0] number_acc;
    logic        digit_seen;
    logic [15:0] held_width;
    logic [15:0] held_height;
    logic [33:0] bytes_left;
    result_t     expected_q[$];
    int          errors;

    function new();
      phase       = PH_P;
      number_acc  = '0;
      digit_seen  = 1'b0;
      held_width  = '0;
      held_height = '0;
      bytes_left  = '0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // folds one digit into the running value; returns 1 on overflow
    function logic gather_digit(logic [7:0] b);
      logic [19:0] grown;
      grown = number_acc * 20'd10 + 20'(b - CH_ZERO);
      if (grown > ACC_LIMIT) return 1'b1;
      number_acc = grown;
      digit_seen = 1'b1;
      return 1'b0;
    endfunction

    // works out the result of one accepted input transaction
    function void note_byte(logic [7:0] b);
      result_t r;
      logic    is_digit;
      logic    bad;
      r        = '0;
      r.kind   = KIND_TAKEN;
      bad      = 1'b0;
      is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
      case (phase)
        PH_SIX: begin
          if (b == CH_SIX) phase = PH_NL;
          else bad = 1'b1;
        end
        PH_NL: begin
          if (b == CH_NL) begin
            phase      = PH_WIDTH;
            number_acc = '0;
            digit_seen = 1'b0;
          end else bad = 1'b1;
        end
        PH_WIDTH: begin
          if (is_digit) bad = gather_digit(b);
          else if (digit_seen && b == CH_SPACE) begin
            held_width = number_acc[15:0];
            number_acc = '0;
            digit_seen = 1'b0;
            phase      = PH_HEIGHT;
          end else bad = 1'b1;
        end
        PH_HEIGHT: begin
          if (is_digit) bad = gather_digit(b);
          else if (digit_seen && b == CH_NL) begin
            held_height = number_acc[15:0];
            number_acc  = '0;
            digit_seen  = 1'b0;
            phase       = PH_MAXV;
          end else bad = 1'b1;
        end
        PH_MAXV: begin
          if (is_digit) bad = gather_digit(b);
          else if (digit_seen && b == CH_NL && number_acc == 20'(MAXVAL)) begin
            r.kind         = KIND_DONE;
            r.frame_width  = held_width;
            r.frame_height = held_height;
            number_acc     = '0;
            digit_seen     = 1'b0;
            bytes_left     = 34'(held_width) * 34'(held_height) * 34'd3;
            phase          = (bytes_left == '0) ? PH_P : PH_PIXELS;
          end else bad = 1'b1;
        end
        PH_PIXELS: begin
          r.kind         = KIND_PIXEL;
          r.pixel_value  = b;
          r.frame_width  = held_width;
          r.frame_height = held_height;
          if (bytes_left <= 34'd1) begin
            r.last_pixel = 1'b1;
            bytes_left   = '0;
            phase        = PH_P;
          end else begin
            bytes_left = bytes_left - 34'd1;
          end
        end
        default: begin
          if (b == CH_P) phase = PH_SIX;
          else bad = 1'b1;
        end
      endcase
      // the offending byte is consumed, matching restarts at letter p
      if (bad) begin
        r.kind     = KIND_ERROR;
        phase      = PH_P;
        number_acc = '0;
        digit_seen = 1'b0;
      end
      expected_q.push_back(r);
    endfunction

    function void report(string field, logic [15:0] want, logic [15:0] got);
      errors++;
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] pixel_value,
                               logic [15:0] frame_width, logic [15:0] frame_height,
                               logic last_pixel);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: none predicted, actual kind %0d", $time, kind);
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.kind) report("kind", 16'(want.kind), 16'(kind));
      if (pixel_value !== want.pixel_value)
        report("pixel_value", 16'(want.pixel_value), 16'(pixel_value));
      if (frame_width !== want.frame_width)
        report("frame_width", want.frame_width, frame_width);
      if (frame_height !== want.frame_height)
        report("frame_height", want.frame_height, frame_height);
      if (last_pixel !== want.last_pixel)
        report("last_pixel", 16'(want.last_pixel), 16'(last_pixel));
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_LIMIT    = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  stream_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  kind_o;
  logic [7:0]  pixel_value_o;
  logic [15:0] frame_width_o;
  logic [15:0] frame_height_o;
  logic        last_pixel_o;

  frame_scoreboard sb = new();

  int tx_idle_pct;     // chance per cycle that the sender holds back
  int rx_stall_pct;    // chance per cycle that the receiver is not ready
  int rx_hold;         // pending long hold-off of the receiver, in cycles
  int bytes_sent;
  int quiet_cycles;

  ppm_p6_header_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stream_byte_i (stream_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .pixel_value_o (pixel_value_o),
    .frame_width_o (frame_width_o),
    .frame_height_o(frame_height_o),
    .last_pixel_o  (last_pixel_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver side: random stalls, plus a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // result check and watchdog, both on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(kind_o, pixel_value_o, frame_width_o, frame_height_o, last_pixel_o);
      // any transaction on either side counts as progress
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("ppm_p6_header_parser_core_tb NOT OK");
        $finish;
      end
    end
  end

  // entered and left at a falling edge; valid stays up from one byte to the next unless the sender idles
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // sends s[0 .. stop_at-1]; the byte at bad_at is swapped for a random one
  task automatic send_text(input string s, input int bad_at, input int stop_at);
    logic [7:0] b;
    for (int i = 0; i < s.len() && i < stop_at; i++) begin
      b = s[i];
      if (i == bad_at) b = 8'($urandom_range(255));
      send_byte(b);
    end
  endtask

  task automatic send_clean(input string s);
    send_text(s, -1, s.len());
  endtask

  // decimal text, now and then with leading zeros
  function automatic string dec_text(int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(9) == 0) s = {"00", s};
    return s;
  endfunction

  // mostly well-formed frames with random pixels; some corrupt, cut or noisy
  task automatic send_random_frame();
    int unsigned w;
    int unsigned h;
    int unsigned roll;
    int          bad_at;
    int          stop_at;
    string       hdr;
    roll = $urandom_range(99);
    w    = $urandom_range(4);
    h    = $urandom_range(3);
    // a big dimension against a zero one keeps the frame empty; some overflow
    if (roll < 6) begin
      if ($urandom_range(1)) begin
        w = $urandom_range(70000);
        h = 0;
      end else begin
        w = 0;
        h = $urandom_range(70000);
      end
    end
    hdr     = {"P6\n", dec_text(w), " ", dec_text(h), "\n", dec_text(255), "\n"};
    bad_at  = (roll >= 6 && roll < 20) ? $urandom_range(hdr.len() - 1) : -1;
    stop_at = (roll >= 20 && roll < 25) ? $urandom_range(hdr.len() - 1) : hdr.len();
    send_text(hdr, bad_at, stop_at);
    if (stop_at == hdr.len())
      repeat (w * h * 3) send_byte(8'($urandom_range(255)));
    // stray bytes between frames
    if (roll >= 90) repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
  endtask

  task automatic run_random(input int tx_pct, input int rx_pct, input int budget);
    int stop_at;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    stop_at      = bytes_sent + budget;
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  initial begin
    int guard;
    in_valid_i    = 1'b0;
    stream_byte_i = 8'h00;
    rst_ni        = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    rx_hold       = 0;
    bytes_sent    = 0;
    quiet_cycles  = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: smallest frame, pixel extremes, last pixel marking
    send_clean("P6\n1 1\n255\n");
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'ha5);
    // zero-size frames with an all-ones dimension and leading zeros
    send_clean("P6\n65535 0\n255\n");
    send_clean("P6\n00000 65535\n0255\n");
    // number too large at the last digit
    send_clean("P6\n65536");
    // missing digits before each separator
    send_clean("P6\n 1");
    send_clean("P6\n1 \n");
    send_clean("P6\n1 1\n\n");
    // wrong separators and a wrong maximum
    send_clean("P6\n1\n");
    send_clean("P6\n1 1 ");
    send_clean("P6\n1 1\n254\n");
    // bad letters and extreme bytes where the header starts
    send_clean("PP");
    send_clean("P7");
    send_clean("P6 ");
    send_byte(8'h00);
    send_byte(8'hff);
    // a header right behind the last pixel of a frame
    send_clean("P6\n2 1\n255\n");
    repeat (6) send_byte(8'($urandom_range(255)));
    send_clean("P6\n0 0\n255\n");

    // receiver holds off for a long stretch while the sender keeps offering
    rx_hold = 400;
    run_random(0, 0, 200);
    run_random(53, 0, 200);
    run_random(0, 53, 200);
    run_random(6, 6, 200);
    in_valid_i <= 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    // let anything unpredicted surface before the verdict
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ppm_p6_header_parser_core_tb OK");
    end else begin
      $display("ppm_p6_header_parser_core_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/php_pkg.sv
rtl/php_frame_size.sv
rtl/php_parser.sv
rtl/ppm_p6_header_parser_core.sv
rtl/php_checker.sv
sim/ppm_p6_header_parser_core_tb.sv
